[rtl/core/lit_pkg.sv]
// Package: action codes, field widths and divider handshake types for the interval timer.
`timescale 1ns / 1ps

package lit_pkg;

   localparam int ACTION_W = 3;
   localparam int DELTA_W  = 16;
   localparam int TIME_W   = 32;
   localparam int PROG_W   = 17;
   localparam int STEP_W   = 6;

   localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_START   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_STOP    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_PAUSE   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RESTART = 3'd4;

   localparam logic [0:0] REG_DURATION = 1'b0;
   localparam logic [0:0] REG_INTERVAL = 1'b1;

   localparam logic [PROG_W-1:0] PROG_FULL = 17'h10000;

   localparam logic [STEP_W-1:0] STEPS_MOD  = 6'd32;
   localparam logic [STEP_W-1:0] STEPS_PROG = 6'd16;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [TIME_W-1:0] rem_init;
      logic [TIME_W-1:0] num_init;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [TIME_W-1:0] quotient;
      logic [TIME_W-1:0] remainder;
   } div_rsp_type;

endpackage

[rtl/core/lit_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, shared by modulo and progress.
`timescale 1ns / 1ps

module lit_div
   import lit_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       req,
   input  logic [TIME_W-1:0] divisor,
   output div_rsp_type       rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] num_ff, num_in;
   logic [TIME_W-1:0] quo_ff, quo_in;

   logic [TIME_W:0] trial;
   logic [TIME_W:0] diff;
   logic            qbit;

   always_comb begin
      trial = {rem_ff, num_ff[TIME_W-1]};
      diff  = trial - {1'b0, divisor};
      qbit  = (trial >= {1'b0, divisor});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         rem_in  = req.rem_init;
         num_in  = req.num_init;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         num_in = {num_ff[TIME_W-2:0], 1'b0};
         quo_in = {quo_ff[TIME_W-2:0], qbit};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

[rtl/core/looping_interval_timer_top.sv]
// Top level of the looping interval timer: sequencer, timer state and stream ports.
// Flow per beat: accept, exec, a boundary check for ticks while running, a divider modulo when
// a loop wraps, progress (divided out unless elapsed is at or past the end), then the result.
// One item at a time: the next beat is taken after the result beat leaves.
// Both divisions share the one-bit-per-cycle divider (32 steps wrap, 16 steps progress).
// Reset (synchronous, active high) clears timer state and both registers to zero at once.
`timescale 1ns / 1ps

module looping_interval_timer_top
   import lit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // action[2:0], delta_ms[18:3], looped[19], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // running[0], fired[1], elapsed_ms[33:2], progress[50:34]
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_MOD   = 3'd3;
   localparam logic [2:0] S_PROG  = 3'd4;
   localparam logic [2:0] S_PWAIT = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [TIME_W-1:0]   duration_ff, duration_in;
   logic [TIME_W-1:0]   interval_ff, interval_in;
   logic                running_ff, running_in;
   logic                loop_ff, loop_in;
   logic [TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic [TIME_W-1:0]   icount_ff, icount_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [DELTA_W-1:0]  delta_ff, delta_in;
   logic                looped_ff, looped_in;
   logic [TIME_W-1:0]   iv_ff, iv_in;
   logic [TIME_W-1:0]   isum_ff, isum_in;
   logic                fired_ff, fired_in;
   logic [PROG_W-1:0]   prog_ff, prog_in;

   logic [TIME_W:0]     el_sum;
   logic [TIME_W:0]     ic_sum;
   logic                boundary;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   lit_div u_div (
      .clock   (clock),
      .reset   (reset),
      .req     (div_req),
      .divisor (duration_ff),
      .rsp     (div_rsp)
   );

   always_comb begin
      el_sum   = {1'b0, elapsed_ff} + {{(TIME_W-DELTA_W+1){1'b0}}, delta_ff};
      ic_sum   = {1'b0, icount_ff} + {{(TIME_W-DELTA_W+1){1'b0}}, delta_ff};
      boundary = (iv_ff == '0) || (isum_ff >= iv_ff) || (isum_ff == '0);
   end

   always_comb begin
      state_in    = state_ff;
      duration_in = duration_ff;
      interval_in = interval_ff;
      running_in  = running_ff;
      loop_in     = loop_ff;
      elapsed_in  = elapsed_ff;
      icount_in   = icount_ff;
      action_in   = action_ff;
      delta_in    = delta_ff;
      looped_in   = looped_ff;
      iv_in       = iv_ff;
      isum_in     = isum_ff;
      fired_in    = fired_ff;
      prog_in     = prog_ff;
      div_req     = '0;

      if (csr_we) begin
         if (csr_index == REG_DURATION) begin
            duration_in = csr_wdata;
         end else begin
            interval_in = csr_wdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               action_in = req_tdata[2:0];
               delta_in  = req_tdata[18:3];
               looped_in = req_tdata[19];
               fired_in  = 1'b0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_PROG;
            case (action_ff)
               ACT_TICK: begin
                  if (running_ff) begin
                     elapsed_in = el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];
                     isum_in    = ic_sum[TIME_W] ? '1 : ic_sum[TIME_W-1:0];
                     iv_in      = (interval_ff < duration_ff) ? interval_ff : duration_ff;
                     state_in   = S_CHECK;
                  end
               end
               ACT_START: begin
                  if (!running_ff && duration_ff != '0) begin
                     loop_in    = looped_ff;
                     running_in = 1'b1;
                     elapsed_in = '0;
                     icount_in  = '0;
                     fired_in   = 1'b1;
                  end
               end
               ACT_STOP: begin
                  running_in = 1'b0;
                  elapsed_in = '0;
                  icount_in  = '0;
               end
               ACT_PAUSE: begin
                  running_in = !running_ff;
               end
               ACT_RESTART: begin
                  running_in = (duration_ff != '0);
                  fired_in   = (duration_ff != '0);
                  elapsed_in = '0;
                  icount_in  = '0;
               end
               default: begin
               end
            endcase
         end
         S_CHECK: begin
            state_in = S_PROG;
            if (iv_ff != '0) begin
               icount_in = (isum_ff >= iv_ff) ? '0 : isum_ff;
            end
            if (boundary) begin
               fired_in = 1'b1;
               if (elapsed_ff >= duration_ff) begin
                  if (loop_ff && duration_ff != '0) begin
                     div_req.start    = 1'b1;
                     div_req.steps    = STEPS_MOD;
                     div_req.rem_init = '0;
                     div_req.num_init = elapsed_ff;
                     state_in         = S_MOD;
                  end else begin
                     elapsed_in = duration_ff;
                     running_in = 1'b0;
                  end
               end
            end
         end
         S_MOD: begin
            if (div_rsp.done) begin
               elapsed_in = div_rsp.remainder;
               state_in   = S_PROG;
            end
         end
         S_PROG: begin
            if (elapsed_ff >= duration_ff) begin
               prog_in  = PROG_FULL;
               state_in = S_OUT;
            end else begin
               div_req.start    = 1'b1;
               div_req.steps    = STEPS_PROG;
               div_req.rem_init = elapsed_ff;
               div_req.num_init = '0;
               state_in         = S_PWAIT;
            end
         end
         S_PWAIT: begin
            if (div_rsp.done) begin
               prog_in  = {1'b0, div_rsp.quotient[15:0]};
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         duration_ff <= '0;
         interval_ff <= '0;
         running_ff  <= 1'b0;
         loop_ff     <= 1'b0;
         elapsed_ff  <= '0;
         icount_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         duration_ff <= duration_in;
         interval_ff <= interval_in;
         running_ff  <= running_in;
         loop_ff     <= loop_in;
         elapsed_ff  <= elapsed_in;
         icount_ff   <= icount_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      delta_ff  <= delta_in;
      looped_ff <= looped_in;
      iv_ff     <= iv_in;
      isum_ff   <= isum_in;
      fired_ff  <= fired_in;
      prog_ff   <= prog_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {5'b0, prog_ff, elapsed_ff, fired_ff, running_ff};

endmodule

[rtl/core/lit_checker.sv]
// Port-level checks for the interval timer, bound to the top level.
`timescale 1ns / 1ps

module lit_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input taken while a result beat is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("block not busy right after an accepted beat");

   a_progress_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[50:34] <= 17'h10000)
      else $error("progress above full scale");

endmodule

bind looping_interval_timer_top lit_checker u_lit_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[bench/looping_interval_timer_top_tb.sv]
// Self-checking testbench for the looping interval timer: random and directed beats, predicted status.
`timescale 1ns / 1ps

module looping_interval_timer_top_tb;
   import lit_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 1_000_000;
   localparam int unsigned PHASE_ITEMS      = 200;
   localparam int unsigned TAIL_ITEMS       = 200;
   localparam int unsigned LONG_HOLD_AT     = 60;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES    = 64;

   typedef struct packed {
      logic               looped;
      logic [DELTA_W-1:0] delta;
      logic [ACTION_W-1:0] action;
   } timer_cmd_type;

   typedef struct packed {
      logic [PROG_W-1:0] progress;
      logic [TIME_W-1:0] elapsed;
      logic              fired;
      logic              running;
   } timer_status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = REG_DURATION;
   logic [31:0] csr_wdata = '0;

   looping_interval_timer_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Timer shadow: configuration and state
   logic [TIME_W-1:0] cfg_duration = '0;
   logic [TIME_W-1:0] cfg_interval = '0;
   logic              tm_running   = 1'b0;
   logic              tm_loop      = 1'b0;
   logic [TIME_W-1:0] tm_elapsed   = '0;
   logic [TIME_W-1:0] tm_icount    = '0;

   timer_cmd_type    pending_cmds[$];
   timer_status_type expected_status[$];
   int unsigned      fail_count = 0;
   int unsigned      cycle_count = 0;
   logic             quiet = 1'b0;

   function automatic logic timer_advance(logic [DELTA_W-1:0] delta);
      logic [TIME_W:0]   sum;
      logic [TIME_W-1:0] gate;
      if (!tm_running) return 1'b0;
      sum = {1'b0, tm_elapsed} + (TIME_W+1)'(delta);
      tm_elapsed = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      gate = (cfg_interval < cfg_duration) ? cfg_interval : cfg_duration;
      if (gate != '0) begin
         sum = {1'b0, tm_icount} + (TIME_W+1)'(delta);
         tm_icount = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
         if (tm_icount >= gate) tm_icount = '0;
      end
      if (gate == '0 || tm_icount == '0) begin
         if (tm_elapsed >= cfg_duration) begin
            if (tm_loop && cfg_duration != '0) begin
               tm_elapsed = tm_elapsed % cfg_duration;
            end else begin
               tm_elapsed = cfg_duration;
               tm_running = 1'b0;
            end
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void timer_clear();
      tm_running = 1'b0;
      tm_elapsed = '0;
      tm_icount  = '0;
   endfunction

   function automatic logic timer_start(logic loop_req);
      if (tm_running || cfg_duration == '0) return 1'b0;
      tm_loop    = loop_req;
      tm_running = 1'b1;
      tm_elapsed = '0;
      tm_icount  = '0;
      return timer_advance('0);
   endfunction

   function automatic logic [PROG_W-1:0] timer_progress();
      logic [47:0] q;
      if (cfg_duration == '0) return PROG_FULL;
      q = {tm_elapsed, 16'h0000} / {16'h0000, cfg_duration};
      return (q > 48'(PROG_FULL)) ? PROG_FULL : q[PROG_W-1:0];
   endfunction

   function automatic timer_status_type step_timer(timer_cmd_type cmd);
      timer_status_type st;
      logic             strobe;
      strobe = 1'b0;
      case (cmd.action)
         ACT_TICK:    strobe = timer_advance(cmd.delta);
         ACT_START:   strobe = timer_start(cmd.looped);
         ACT_STOP:    timer_clear();
         ACT_PAUSE:   tm_running = !tm_running;
         ACT_RESTART: begin
            timer_clear();
            strobe = timer_start(tm_loop);
         end
         default: ;
      endcase
      st.running  = tm_running;
      st.fired    = strobe;
      st.elapsed  = tm_elapsed;
      st.progress = timer_progress();
      return st;
   endfunction

   function automatic void add_cmd(logic [ACTION_W-1:0] action, logic [DELTA_W-1:0] delta,
                                   logic looped);
      timer_cmd_type cmd;
      cmd.action = action;
      cmd.delta  = delta;
      cmd.looped = looped;
      pending_cmds.push_back(cmd);
   endfunction

   function automatic timer_cmd_type random_cmd(int unsigned dmax);
      timer_cmd_type cmd;
      int unsigned   pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)      cmd.action = ACT_TICK;
      else if (pick < 68) cmd.action = ACT_START;
      else if (pick < 74) cmd.action = ACT_STOP;
      else if (pick < 82) cmd.action = ACT_PAUSE;
      else if (pick < 90) cmd.action = ACT_RESTART;
      else if (pick < 95) cmd.action = ACTION_W'(ACT_RESTART + 1 + $urandom_range(0, 2));
      else                cmd.action = ACT_TICK;
      case ($urandom_range(0, 15))
         0:       cmd.delta = '0;
         1:       cmd.delta = '1;
         2:       cmd.delta = DELTA_W'($urandom_range(0, 65535));
         default: cmd.delta = DELTA_W'($urandom_range(0, dmax));
      endcase
      cmd.looped = 1'($urandom_range(0, 1));
      return cmd;
   endfunction

   // Sender: offer queued beats, predict on accept
   timer_cmd_type offered;
   int unsigned   send_gap = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_status.push_back(step_timer(offered));
            if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 16);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               offered = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {4'b0000, offered};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure: random bursts and one long hold
   int unsigned rsp_stall = 0;
   int unsigned long_hold = 0;
   int unsigned beats_out = 0;
   logic        long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) beats_out = beats_out + 1;
         if (long_hold != 0) begin
            long_hold = long_hold - 1;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && beats_out >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            long_hold = LONG_HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_stall != 0) begin
            rsp_stall = rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Checker
   timer_status_type got;
   timer_status_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[50:0];
         if (expected_status.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected status beat: running=%0d fired=%0d elapsed=%0d progress=%0d",
                        got.running, got.fired, got.elapsed, got.progress);
            fail_count = fail_count + 1;
         end else begin
            want = expected_status.pop_front();
            if (got.running !== want.running || got.fired !== want.fired ||
                got.elapsed !== want.elapsed || got.progress !== want.progress) begin
               if (fail_count < 10)
                  $display("status mismatch: expected running=%0d fired=%0d elapsed=%0d %s%0d",
                           want.running, want.fired, want.elapsed, "progress=", want.progress,
                           "\n                 actual   running=%0d fired=%0d elapsed=%0d %s%0d",
                           got.running, got.fired, got.elapsed, "progress=", got.progress);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic drain_all();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || expected_status.size() != 0);
   endtask

   task automatic program_timer(logic [TIME_W-1:0] duration, logic [TIME_W-1:0] interval);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_DURATION;
      csr_wdata <= duration;
      cfg_duration = duration;
      @(posedge clock);
      csr_index <= REG_INTERVAL;
      csr_wdata <= interval;
      cfg_interval = interval;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [TIME_W-1:0] dur;
      logic [TIME_W-1:0] ivl;
      int unsigned       dmax;
      int                c;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers still at zero: refused start, spare codes, resume with no duration
      add_cmd(ACT_TICK, '1, 1'b0);
      add_cmd(ACT_START, '0, 1'b1);
      for (c = ACT_RESTART + 1; c < (1 << ACTION_W); c++) add_cmd(ACTION_W'(c), '1, 1'b1);
      add_cmd(ACT_RESTART, '0, 1'b0);
      add_cmd(ACT_PAUSE, '0, 1'b0);
      add_cmd(ACT_TICK, 16'd5, 1'b0);
      drain_all();

      // one-shot end, resume past the end, loop wrap, restart
      program_timer(32'd1000, 32'd0);
      add_cmd(ACT_START, '0, 1'b0);
      add_cmd(ACT_START, '0, 1'b1);
      add_cmd(ACT_TICK, 16'd999, 1'b0);
      add_cmd(ACT_TICK, 16'd1, 1'b0);
      add_cmd(ACT_PAUSE, '0, 1'b0);
      add_cmd(ACT_TICK, '0, 1'b0);
      add_cmd(ACT_START, '0, 1'b1);
      add_cmd(ACT_TICK, '1, 1'b0);
      add_cmd(ACT_RESTART, '0, 1'b0);
      drain_all();

      // interval above duration gets clamped
      program_timer(32'd1000, 32'd5000);
      add_cmd(ACT_TICK, 16'd600, 1'b0);
      add_cmd(ACT_TICK, 16'd600, 1'b0);
      drain_all();

      // duration cleared while running
      program_timer(32'd0, 32'd5000);
      add_cmd(ACT_TICK, '0, 1'b0);
      add_cmd(ACT_STOP, '0, 1'b0);
      drain_all();

      for (int p = 0; p < 9; p++) begin
         case (p)
            0: begin dur = 32'd1000;      ivl = 32'd0;      dmax = 300;   end
            1: begin dur = 32'd1000;      ivl = 32'd250;    dmax = 120;   end
            2: begin dur = 32'd7;         ivl = 32'd3;      dmax = 5;     end
            3: begin dur = 32'd1;         ivl = 32'd1;      dmax = 2;     end
            4: begin dur = 32'd50000;     ivl = 32'd70000;  dmax = 65535; end
            5: begin
               dur  = $urandom_range(1, 200000);
               ivl  = $urandom_range(0, dur);
               dmax = 65535;
            end
            6: begin dur = 32'd0;         ivl = $urandom;   dmax = 65535; end
            7: begin dur = 32'hFFFF_FFFF; ivl = $urandom;   dmax = 65535; end
            default: begin dur = 32'd300; ivl = '1;         dmax = 100;   end
         endcase
         program_timer(dur, ivl);
         repeat (PHASE_ITEMS) pending_cmds.push_back(random_cmd(dmax));
         drain_all();
      end

      // closing stretch with long run time and wide interval, no idling
      quiet = 1'b1;
      program_timer('1, 32'd65535);
      add_cmd(ACT_START, '0, 1'b1);
      repeat (TAIL_ITEMS) pending_cmds.push_back(random_cmd(65535));
      drain_all();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_status.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
